// ----- design/coe_pkg.sv -----
`timescale 1ns / 1ps

package coe_pkg;

    // request kinds on the input stream
    typedef enum logic [1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_VALUE   = 2'd1,
        CMD_NEW_MSG = 2'd2,
        CMD_UNUSED  = 2'd3
    } coe_cmd_t;

    localparam logic [3:0]  EXT8_CODE  = 4'd13;
    localparam logic [3:0]  EXT16_CODE = 4'd14;
    localparam logic [15:0] EXT8_BIAS  = 16'd13;
    localparam logic [15:0] EXT16_BIAS = 16'd269;

    localparam int JOB_BYTES = 5;

    // one queued output run: bytes go out lowest first
    typedef struct packed {
        logic [8*JOB_BYTES-1:0] bytes;
        logic [2:0]             count;
        logic                   last;
        logic                   done;
        logic                   err;
    } coe_job_t;

    typedef struct packed {
        logic     valid;
        coe_job_t job;
    } coe_push_t;

endpackage

// ----- design/coap_option_encoder.sv -----
`timescale 1ns / 1ps

// CoAP option encoder: turns begin / value / new-message requests into the
// delta/length option byte stream. A begin request yields one to five bytes
// (header, extended delta, extended length), a value request yields one
// passed-through byte, a new-message request clears the running option number
// and yields nothing. Input requests are taken at one per cycle while the run
// queue has room; the output side sends one byte per cycle while m_tready is
// high, and a stream of value requests then flows at one per cycle. A taken
// request is written into the run queue, then loaded into the back's output
// register, which drives its first byte. Errors (decreasing option number,
// value byte with none expected) give one zero byte with tlast and the error
// flag set. tlast marks the final header byte of a begin request and only the
// final value byte of an option.

module coap_option_encoder #(
    parameter int QUEUE_DEPTH = 4   // runs buffered between front and back, 2 or more
) (
    input  logic        clk,
    input  logic        rst_n,
    // input request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // option_number[15:0], option_length[31:16],
                                   // value_byte[39:32]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // output byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // final header byte, final value byte or error byte
    output logic [1:0]  m_tuser    // option_done[0], error[1]
);
    import coe_pkg::*;

    coe_push_t push;
    coe_job_t  head;
    logic      q_full;
    logic      head_valid;
    logic      pop;

    // front: holds option number and remaining value count, builds runs
    coe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push)
    );

    // short run queue so front and back stall independently
    coe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // back: shifts each run out a byte per cycle while m_tready is high
    coe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- design/coe_front.sv -----
`timescale 1ns / 1ps

module coe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              q_full,
    output coe_pkg::coe_push_t push
);
    import coe_pkg::*;

    typedef struct packed {
        logic [15:0] b;
        logic [1:0]  n;
    } ext_t;

    function automatic logic [3:0] nib_code(input logic [15:0] q);
        if (q < EXT8_BIAS)
            return q[3:0];
        else if (q < EXT16_BIAS)
            return EXT8_CODE;
        else
            return EXT16_CODE;
    endfunction

    // extended bytes, first emitted byte in the low bits
    function automatic ext_t ext_bytes(input logic [15:0] q);
        ext_t        e;
        logic [15:0] t;
        e = '0;
        t = '0;
        if (q < EXT8_BIAS)
        begin
            e.n = 2'd0;
        end
        else if (q < EXT16_BIAS)
        begin
            t = q - EXT8_BIAS;
            e.b = {8'd0, t[7:0]};
            e.n = 2'd1;
        end
        else
        begin
            t = q - EXT16_BIAS;
            e.b = {t[7:0], t[15:8]};
            e.n = 2'd2;
        end
        return e;
    endfunction

    logic [15:0] prev_reg, prev_next;
    logic [15:0] rem_reg, rem_next;

    logic [15:0] number, length, delta;
    logic [7:0]  vbyte;
    coe_cmd_t    cmd;
    logic        accept;
    ext_t        dext, lext;
    logic [7:0]  hdr;
    logic [39:0] hbytes;
    coe_job_t    job;
    logic        want_push;

    assign number = s_tdata[15:0];
    assign length = s_tdata[31:16];
    assign vbyte  = s_tdata[39:32];
    assign cmd    = coe_cmd_t'(s_tuser);

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign delta = number - prev_reg;
    assign dext  = ext_bytes(delta);
    assign lext  = ext_bytes(length);
    assign hdr   = {nib_code(delta), nib_code(length)};

    always_comb
    begin
        hbytes = {32'd0, hdr} | {16'd0, dext.b, 8'd0};
        case (dext.n)
            2'd0:    hbytes = hbytes | {16'd0, lext.b, 8'd0};
            2'd1:    hbytes = hbytes | {8'd0, lext.b, 16'd0};
            2'd2:    hbytes = hbytes | {lext.b, 24'd0};
            default: hbytes = hbytes;
        endcase
    end

    always_comb
    begin
        prev_next = prev_reg;
        rem_next  = rem_reg;
        want_push = 1'b0;
        // error run by default: one zero byte flagged
        job       = '0;
        job.count = 3'd1;
        job.last  = 1'b1;
        job.err   = 1'b1;
        case (cmd)
            CMD_BEGIN:
            begin
                want_push = 1'b1;
                if (number >= prev_reg)
                begin
                    job.bytes = hbytes;
                    job.count = 3'd1 + {1'b0, dext.n} + {1'b0, lext.n};
                    job.done  = (length == 16'd0);
                    job.err   = 1'b0;
                    prev_next = number;
                    rem_next  = length;
                end
            end
            CMD_VALUE:
            begin
                want_push = 1'b1;
                if (rem_reg != 16'd0)
                begin
                    // value bytes carry last only on the option's final byte
                    job.bytes = {32'd0, vbyte};
                    job.last  = (rem_reg == 16'd1);
                    job.done  = (rem_reg == 16'd1);
                    job.err   = 1'b0;
                    rem_next  = rem_reg - 16'd1;
                end
            end
            CMD_NEW_MSG:
            begin
                prev_next = '0;
                rem_next  = '0;
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    assign push.valid = accept && want_push;
    assign push.job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            rem_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg <= prev_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

// ----- design/coe_queue.sv -----
`timescale 1ns / 1ps

module coe_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  coe_pkg::coe_push_t push,
    output logic               full,
    output logic               head_valid,
    output coe_pkg::coe_job_t  head,
    input  logic               pop
);
    import coe_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    coe_job_t      entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push.valid && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.job;
    end

endmodule

// ----- design/coe_back.sv -----
`timescale 1ns / 1ps

module coe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  coe_pkg::coe_job_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);
    import coe_pkg::*;

    logic [8*JOB_BYTES-1:0] bytes_reg;
    logic [2:0]             cnt_reg;
    logic                   last_reg;
    logic                   done_reg;
    logic                   err_reg;
    logic                   run_end;
    logic                   advance;
    logic                   load;

    assign run_end  = (cnt_reg == 3'd1);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = bytes_reg[7:0];
    assign m_tlast  = run_end && last_reg;
    assign m_tuser  = {err_reg, done_reg && run_end};

    assign advance = m_tvalid && m_tready;
    // take the next run when empty or when the final byte leaves
    assign load    = !m_tvalid || (advance && run_end);
    assign pop     = load && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else if (load)
        begin
            cnt_reg <= head_valid ? head.count : 3'd0;
        end
        else if (advance)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bytes_reg <= head.bytes;
            last_reg  <= head.last;
            done_reg  <= head.done;
            err_reg   <= head.err;
        end
        else if (advance)
        begin
            bytes_reg <= {8'd0, bytes_reg[8*JOB_BYTES-1:8]};
        end
    end

endmodule

// ----- tb/sv/coe_option_stream_checker.sv -----
`timescale 1ns / 1ps

module coe_option_stream_checker
    import coe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // option_number[15:0], option_length[31:16],
                                   // value_byte[39:32]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // out_byte[7:0]
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,   // option_done[0], error[1]
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } option_byte_t;

    localparam option_byte_t ERROR_BYTE = '{data: 8'h00, last: 1'b1, done: 1'b0, err: 1'b1};
    localparam int REPORT_LIMIT = 10;

    option_byte_t pending_option_bytes[$];
    logic [15:0]  prev_option_number;
    logic [15:0]  value_bytes_left;
    int           fail_count;

    // 4-bit delta/length code for a quantity
    function automatic logic [3:0] nibble_of(input logic [15:0] q);
        if (q < EXT8_BIAS)
            return q[3:0];
        else if (q < EXT16_BIAS)
            return EXT8_CODE;
        else
            return EXT16_CODE;
    endfunction

    // expected bytes of one begin request: header, extended delta, extended length
    task automatic encode_option_header(input logic [15:0] number, input logic [15:0] length);
        logic [7:0]  run[$];
        logic [15:0] qty[2];
        logic [15:0] ext;
        option_byte_t b;
        int          i;
        if (number < prev_option_number)
        begin
            pending_option_bytes.push_back(ERROR_BYTE);
            return;
        end
        qty[0] = number - prev_option_number;
        qty[1] = length;
        run.push_back({nibble_of(qty[0]), nibble_of(qty[1])});
        for (i = 0; i < 2; i++)
        begin
            if (qty[i] >= EXT16_BIAS)
            begin
                ext = qty[i] - EXT16_BIAS;
                run.push_back(ext[15:8]);
                run.push_back(ext[7:0]);
            end
            else if (qty[i] >= EXT8_BIAS)
            begin
                ext = qty[i] - EXT8_BIAS;
                run.push_back(ext[7:0]);
            end
        end
        for (i = 0; i < run.size(); i++)
        begin
            b.data = run[i];
            b.last = (i == run.size() - 1);
            b.done = b.last && (length == 16'd0);
            b.err  = 1'b0;
            pending_option_bytes.push_back(b);
        end
        prev_option_number = number;
        value_bytes_left   = length;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        option_byte_t exp_b;
        if (!rst_n)
        begin
            prev_option_number = 16'd0;
            value_bytes_left   = 16'd0;
            pending_option_bytes.delete();
            fail_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                case (coe_cmd_t'(s_tuser))
                    CMD_BEGIN:
                        encode_option_header(s_tdata[15:0], s_tdata[31:16]);
                    CMD_VALUE:
                        if (value_bytes_left == 16'd0)
                            pending_option_bytes.push_back(ERROR_BYTE);
                        else
                        begin
                            value_bytes_left = value_bytes_left - 16'd1;
                            exp_b.data = s_tdata[39:32];
                            exp_b.last = (value_bytes_left == 16'd0);
                            exp_b.done = exp_b.last;
                            exp_b.err  = 1'b0;
                            pending_option_bytes.push_back(exp_b);
                        end
                    CMD_NEW_MSG:
                    begin
                        prev_option_number = 16'd0;
                        value_bytes_left   = 16'd0;
                    end
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (pending_option_bytes.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: output byte %h with nothing expected", $realtime, m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_b = pending_option_bytes.pop_front();
                    if (m_tdata !== exp_b.data || m_tlast !== exp_b.last ||
                        m_tuser[0] !== exp_b.done || m_tuser[1] !== exp_b.err)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: expected byte %h last %b done %b err %b, got %h %b %b %b",
                                     $realtime, exp_b.data, exp_b.last, exp_b.done, exp_b.err,
                                     m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                        fail_count++;
                    end
                end
            end

            mismatches  <= fail_count;
            outstanding <= pending_option_bytes.size();
        end
    end

endmodule

// ----- tb/sv/coap_option_encoder_tb.sv -----
`timescale 1ns / 1ps

module coap_option_encoder_tb;

    import coe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;   // far above the slowest legal run
    localparam int RANDOM_TARGET = 200;      // directed plus random requests counted together, unused ones not counted
    localparam int DRAIN_CYCLES  = 20;       // extra wait after the drain so stray bytes can show up

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // option_number[15:0], option_length[31:16],
                                  // value_byte[39:32]
    logic [1:0]  s_tuser  = '0;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_byte[7:0]
    logic        m_tlast;
    logic [1:0]  m_tuser;         // option_done[0], error[1]

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // pacing state for the request side
    int burst_left = 0;
    int requests_sent = 0;

    // pattern state for the output side
    int stall_cycle = 0;
    int stall_mode  = 0;

    always #2 clk = ~clk;

    coap_option_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    coe_option_stream_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // hard stop in case the stream hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output-side back pressure: a new mode is drawn whenever stall_cycle is a
    // multiple of 97 so stalls land on header, extended and value bytes alike
    always @(negedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 97 == 0)
            stall_mode <= int'($urandom_range(0, 3));
        case (stall_mode)
            0: m_tready <= 1'b1;                          // always ready
            1: m_tready <= 1'($urandom_range(0, 1));      // coin flip
            2: m_tready <= (stall_cycle % 5 != 0);        // periodic hiccup
            default: m_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
        endcase
    end

    // one request on the input stream; a burst of random length is followed
    // by a random gap (zero included) so requests arrive back to back or spaced
    task automatic send_request(input coe_cmd_t cmd, input logic [15:0] number,
                                input logic [15:0] length, input logic [7:0] vbyte);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(4, 12))
                                              : int'($urandom_range(0, 3));
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            burst_left = int'($urandom_range(1, 16));
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {vbyte, length, number};
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd != CMD_UNUSED)
            requests_sent++;
    endtask

    // fields a request does not use carry random bits so every data bit toggles
    task automatic begin_option(input logic [15:0] number, input logic [15:0] length);
        send_request(CMD_BEGIN, number, length, 8'($urandom()));
    endtask

    task automatic value_byte(input logic [7:0] vbyte);
        send_request(CMD_VALUE, 16'($urandom()), 16'($urandom()), vbyte);
    endtask

    task automatic new_message();
        send_request(CMD_NEW_MSG, 16'($urandom()), 16'($urandom()), 8'($urandom()));
    endtask

    initial
    begin
        int          pick;
        int          n_vals;
        int          k;
        int unsigned delta;
        int unsigned cur_number;
        logic [15:0] number;
        logic [15:0] length;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: nibble boundaries 12/13/268/269 on delta, 13/268/269 on length
        new_message();
        begin_option(16'd0, 16'd0);          // zero-length option, done on header
        begin_option(16'd12, 16'd1);         // largest direct delta nibble
        value_byte(8'hFF);
        value_byte(8'h5A);                   // unexpected value byte
        begin_option(16'd12, 16'd13);        // repeated option, one extended length byte
        begin_option(16'd25, 16'd268);       // abandons the open option
        begin_option(16'd293, 16'd269);      // delta 268, two extended length bytes
        begin_option(16'd562, 16'd0);        // delta 269, zero length
        begin_option(16'd65535, 16'd65535);  // five-byte header
        value_byte(8'hAA);
        value_byte(8'h55);
        begin_option(16'd100, 16'd2);        // decreasing option number
        new_message();
        value_byte(8'h3C);                   // nothing open after new message
        send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        begin_option(16'd65535, 16'd3);      // largest delta from zero
        value_byte(8'h01);
        value_byte(8'h80);
        value_byte(8'hFE);
        value_byte(8'h00);                   // one too many
        new_message();
        begin_option(16'd0, 16'd65535);
        begin_option(16'd0, 16'd2);
        value_byte(8'h7F);
        value_byte(8'hC3);
        new_message();
        cur_number = 0;

        // random: mostly well-formed options with rising numbers, some noise
        while (requests_sent < RANDOM_TARGET)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 6)
            begin
                new_message();
                cur_number = 0;
            end
            else if (pick < 10)
                send_request(CMD_UNUSED, 16'($urandom()), 16'($urandom()), 8'($urandom()));
            else if (pick < 15)
                value_byte(8'($urandom()));  // often unexpected
            else if (pick < 20)
            begin
                // arbitrary number, usually lower than the running one
                number = 16'($urandom());
                begin_option(number, 16'($urandom_range(0, 3)));
                if (number >= cur_number)
                    cur_number = {16'd0, number};
            end
            else
            begin
                pick = int'($urandom_range(0, 99));
                if (pick < 60)
                    delta = $urandom_range(0, 12);
                else if (pick < 85)
                    delta = $urandom_range(13, 268);
                else if (pick < 95)
                    delta = $urandom_range(269, 2000);
                else
                    delta = $urandom_range(269, 65535);
                if (cur_number + delta > 65535)
                begin
                    new_message();
                    cur_number = 0;
                end
                number = 16'(cur_number + delta);

                pick = int'($urandom_range(0, 99));
                if (pick < 55)
                    length = 16'($urandom_range(0, 4));
                else if (pick < 75)
                    length = 16'($urandom_range(5, 12));
                else if (pick < 88)
                    length = 16'($urandom_range(13, 268));
                else if (pick < 95)
                    length = 16'($urandom_range(269, 600));
                else
                    length = 16'($urandom());

                begin_option(number, length);
                cur_number = {16'd0, number};

                // long values are cut short, the next header abandons them
                n_vals = (length <= 12) ? int'(length) : int'($urandom_range(0, 3));
                if (n_vals > 0 && $urandom_range(0, 19) == 0)
                    n_vals = int'($urandom_range(0, n_vals - 1));
                for (k = 0; k < n_vals; k++)
                    value_byte(8'($urandom()));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then give stray bytes a chance to show up
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/coe_pkg.sv
design/coe_front.sv
design/coe_queue.sv
design/coe_back.sv
design/coap_option_encoder.sv
tb/sv/coe_option_stream_checker.sv
tb/sv/coap_option_encoder_tb.sv
